/* rtl/mpa_pkg.sv */
// Shared types, constants and the float compare for the max pooling block.
`default_nettype none
package mpa_pkg;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_POOL  = 8;
    localparam int ROW_LIMIT     = 1024;
    localparam int ROW_W         = 10;
    localparam int COL_W         = 12;
    localparam int OHM_W         = 4;
    localparam int DIST_W        = 6;
    localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;

    typedef enum logic [2:0] {
        CFG_POOL   = 3'd0,
        CFG_STEP   = 3'd1,
        CFG_HEIGHT = 3'd2,
        CFG_WIDTH  = 3'd3
    } cfg_idx_t;

    // Clamped configuration seen by front and back
    typedef struct packed {
        logic [4:0]       pool;
        logic [3:0]       step;
        logic [10:0]      height;
        logic [COL_W:0]   width;
    } cfg_t;

    // One pixel with its position and its nearest window
    typedef struct packed {
        logic [31:0]      pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [3:0]       rem_r;
        logic [3:0]       rem_c;
        logic [ROW_W-1:0] oh_hi;
        logic [OHM_W-1:0] ohm;
        logic [COL_W-1:0] ow_hi;
    } item_t;

    // a > b on IEEE single bit patterns; false if either is NaN
    function automatic logic fgt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic res;
        a_nan = (&a[30:23]) && (|a[22:0]);
        b_nan = (&b[30:23]) && (|b[22:0]);
        if (a_nan || b_nan) res = 1'b0;
        else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) res = 1'b0;
        else if (!a[31] && b[31]) res = 1'b1;
        else if (a[31] && !b[31]) res = 1'b0;
        else if (!a[31]) res = a[30:0] > b[30:0];
        else res = a[30:0] < b[30:0];
        return res;
    endfunction
endpackage
`default_nettype wire

/* rtl/mpa_front.sv */
// Front part: position counters that tag every accepted pixel.
`default_nettype none
module mpa_front #(
    parameter int MAX_POOL = mpa_pkg::DEF_MAX_POOL
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mpa_pkg::cfg_t cfg,
    input  wire logic          restart,
    input  wire logic          accept,
    input  wire logic [31:0]   pix,
    output mpa_pkg::item_t     item
);
    import mpa_pkg::*;

    logic [ROW_W-1:0] row_reg, oh_reg;
    logic [COL_W-1:0] col_reg, ow_reg;
    logic [3:0]       remr_reg, remc_reg;
    logic [OHM_W-1:0] ohm_reg;

    logic col_end, row_end, remc_end, remr_end;

    assign col_end  = ({1'b0, col_reg} + 1'b1) == cfg.width;
    assign row_end  = ({1'b0, row_reg} + 1'b1) == cfg.height;
    assign remc_end = (remc_reg + 1'b1) == cfg.step;
    assign remr_end = (remr_reg + 1'b1) == cfg.step;

    always_comb
    begin
        item.pix   = pix;
        item.row   = row_reg;
        item.col   = col_reg;
        item.rem_r = remr_reg;
        item.rem_c = remc_reg;
        item.oh_hi = oh_reg;
        item.ohm   = ohm_reg;
        item.ow_hi = ow_reg;
    end

    // raster counters with running quotient and remainder by the step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0; col_reg <= '0; remr_reg <= '0; remc_reg <= '0;
            oh_reg <= '0; ow_reg <= '0; ohm_reg <= '0;
        end
        else if (restart)
        begin
            row_reg <= '0; col_reg <= '0; remr_reg <= '0; remc_reg <= '0;
            oh_reg <= '0; ow_reg <= '0; ohm_reg <= '0;
        end
        else if (accept)
        begin
            if (!col_end)
            begin
                col_reg <= col_reg + 1'b1;
                if (remc_end)
                begin
                    remc_reg <= '0;
                    ow_reg   <= ow_reg + 1'b1;
                end
                else
                    remc_reg <= remc_reg + 1'b1;
            end
            else
            begin
                col_reg <= '0; remc_reg <= '0; ow_reg <= '0;
                if (row_end)
                begin
                    row_reg <= '0; remr_reg <= '0; oh_reg <= '0; ohm_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    if (remr_end)
                    begin
                        remr_reg <= '0;
                        oh_reg   <= oh_reg + 1'b1;
                        ohm_reg  <= (ohm_reg == OHM_W'(MAX_POOL - 1)) ? '0 : ohm_reg + 1'b1;
                    end
                    else
                        remr_reg <= remr_reg + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/mpa_fifo.sv */
// Two-entry queue of tagged pixels between front and back.
`default_nettype none
module mpa_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire mpa_pkg::item_t wdata,
    output logic                full,
    input  wire logic           rd,
    output mpa_pkg::item_t      rdata,
    output logic                empty
);
    import mpa_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

/* rtl/mpa_back.sv */
// Back part: walks the windows a pixel touches, updates the store, emits results.
`default_nettype none
module mpa_back #(
    parameter int MAX_WIDTH = mpa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_POOL  = mpa_pkg::DEF_MAX_POOL
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mpa_pkg::cfg_t  cfg,
    input  wire mpa_pkg::item_t head,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic                empty,
    input  wire logic           pop,
    output logic [31:0]         max_bits,
    output logic [9:0]          out_row,
    output logic [9:0]          out_col,
    output logic [9:0]          arg_row,
    output logic [9:0]          arg_col,
    output logic                last_of_plane
);
    import mpa_pkg::*;

    localparam int DEPTH = MAX_POOL * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {IDLE, RD, UPD} state_t;

    state_t           state_reg;
    item_t            it_reg;
    logic [DIST_W-1:0] dr_reg, dc_reg;
    logic [ROW_W-1:0] oh_reg;
    logic [OHM_W-1:0] ohm_reg;
    logic [COL_W-1:0] ow_reg;

    logic [31:0]      mx_mem [DEPTH];
    logic [ROW_W-1:0] ar_mem [DEPTH];
    logic [COL_W-1:0] ac_mem [DEPTH];
    logic [31:0]      mx_rd_reg;
    logic [ROW_W-1:0] ar_rd_reg;
    logic [COL_W-1:0] ac_rd_reg;

    logic             ov_reg;
    logic [31:0]      omax_reg;
    logic [9:0]       orow_reg, ocol_reg, oar_reg, oac_reg;
    logic             olast_reg;

    logic [AW-1:0]     addr;
    logic [ROW_W-1:0]  r0;
    logic [COL_W-1:0]  c0;
    logic              whole, first, closing, last, emit, stall, upd, wr_en;
    logic [31:0]       cur_max, new_max;
    logic [ROW_W-1:0]  cur_ar, new_ar;
    logic [COL_W-1:0]  cur_ac, new_ac;
    logic [DIST_W-1:0] dc_n, dr_n, p_ext;
    logic              col_ok, row_ok, any_win;

    assign addr  = AW'(int'(ohm_reg) * MAX_WIDTH + int'(ow_reg));
    assign p_ext = DIST_W'(cfg.pool);

    // window geometry for the current step of the walk
    always_comb
    begin
        r0      = it_reg.row - ROW_W'(dr_reg);
        c0      = it_reg.col - COL_W'(dc_reg);
        whole   = (12'(r0) + 12'(cfg.pool) <= 12'(cfg.height)) &&
                  (14'(c0) + 14'(cfg.pool) <= 14'(cfg.width));
        last    = (12'(r0) + 12'(cfg.step) + 12'(cfg.pool) > 12'(cfg.height)) &&
                  (14'(c0) + 14'(cfg.step) + 14'(cfg.pool) > 14'(cfg.width));
        first   = (dr_reg == '0) && (dc_reg == '0);
        closing = (dr_reg == p_ext - 1'b1) && (dc_reg == p_ext - 1'b1);
        cur_max = first ? NEG_INF_BITS : mx_rd_reg;
        cur_ar  = first ? r0 : ar_rd_reg;
        cur_ac  = first ? c0 : ac_rd_reg;
        upd     = fgt(it_reg.pix, cur_max);
        new_max = upd ? it_reg.pix : cur_max;
        new_ar  = upd ? it_reg.row : cur_ar;
        new_ac  = upd ? it_reg.col : cur_ac;
        emit    = (state_reg == UPD) && whole && closing;
        stall   = emit && ov_reg && !pop;
        wr_en   = (state_reg == UPD) && whole && !stall;
        dc_n    = dc_reg + DIST_W'(cfg.step);
        dr_n    = dr_reg + DIST_W'(cfg.step);
        col_ok  = (dc_n < p_ext) && (dc_n <= DIST_W'(it_reg.col > COL_W'(63) ? 63 : it_reg.col));
        row_ok  = (dr_n < p_ext) && (dr_n <= DIST_W'(it_reg.row > ROW_W'(63) ? 63 : it_reg.row));
        any_win = (DIST_W'(head.rem_r) < p_ext) && (DIST_W'(head.rem_c) < p_ext);
        q_pop   = (state_reg == IDLE) && !q_empty;
    end

    // window store, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == RD)
        begin
            mx_rd_reg <= mx_mem[addr];
            ar_rd_reg <= ar_mem[addr];
            ac_rd_reg <= ac_mem[addr];
        end
        if (wr_en)
        begin
            mx_mem[addr] <= new_max;
            ar_mem[addr] <= new_ar;
            ac_mem[addr] <= new_ac;
        end
    end

    // walk sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ov_reg    <= 1'b0;
            omax_reg  <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            oar_reg   <= '0;
            oac_reg   <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            if (emit && !stall)
            begin
                ov_reg    <= 1'b1;
                omax_reg  <= new_max;
                orow_reg  <= oh_reg;
                ocol_reg  <= ow_reg[9:0];
                oar_reg   <= new_ar;
                oac_reg   <= new_ac[9:0];
                olast_reg <= last;
            end
            else if (pop)
                ov_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (!q_empty)
                        state_reg <= any_win ? RD : IDLE;
                end
                RD:
                    state_reg <= UPD;
                UPD:
                begin
                    if (!stall)
                    begin
                        if (col_ok)
                            state_reg <= RD;
                        else if (row_ok)
                            state_reg <= RD;
                        else
                            state_reg <= IDLE;
                    end
                end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            it_reg  <= head;
            dr_reg  <= DIST_W'(head.rem_r);
            dc_reg  <= DIST_W'(head.rem_c);
            oh_reg  <= head.oh_hi;
            ohm_reg <= head.ohm;
            ow_reg  <= head.ow_hi;
        end
        else if (state_reg == UPD && !stall)
        begin
            if (col_ok)
            begin
                dc_reg <= dc_n;
                ow_reg <= ow_reg - 1'b1;
            end
            else if (row_ok)
            begin
                dr_reg  <= dr_n;
                dc_reg  <= DIST_W'(it_reg.rem_c);
                ow_reg  <= it_reg.ow_hi;
                oh_reg  <= oh_reg - 1'b1;
                ohm_reg <= (ohm_reg == '0) ? OHM_W'(MAX_POOL - 1) : ohm_reg - 1'b1;
            end
        end
    end

    assign empty         = !ov_reg;
    assign max_bits      = omax_reg;
    assign out_row       = orow_reg;
    assign out_col       = ocol_reg;
    assign arg_row       = oar_reg;
    assign arg_col       = oac_reg;
    assign last_of_plane = olast_reg;

    // a blocked result holds the walk in place
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> state_reg == UPD)
        else $error("walk moved on while result was blocked");
    // a store read is always followed by its update step
    a_rd_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == RD |=> state_reg == UPD)
        else $error("read not followed by update");
    // the queue is only drained when the walk is free
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == IDLE && !q_empty)
        else $error("queue popped while busy");
endmodule
`default_nettype wire

/* rtl/max_pool_with_argmax.sv */
// Streaming 2-D max pooling with argmax, top level.
// A result is registered in the update step of the pixel's closing window;
// the closing window is walked last. The walk over the window store takes a read step
// and an update step for each window a pixel touches (up to ceil(pool/step)^2); the
// next pixel leaves the queue only when the walk is idle, and a blocked result stalls it.
// Reset (rst_n, async low) clears counters, queue pointers and the control, config and
// output registers; the window store needs no clearing, a window's first pixel starts from minus infinity.
`default_nettype none
module max_pool_with_argmax #(
    parameter int MAX_WIDTH = mpa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_POOL  = mpa_pkg::DEF_MAX_POOL
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] pixel_bits,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      max_bits,
    output logic [9:0]       out_row,
    output logic [9:0]       out_col,
    output logic [9:0]       arg_row,
    output logic [9:0]       arg_col,
    output logic             last_of_plane,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    import mpa_pkg::*;

    logic [3:0]  pool_reg, step_reg;
    logic [10:0] height_reg, width_reg;
    cfg_t        cfg;
    logic        cfg_hit, accept, q_empty, q_pop;
    item_t       front_item, head;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index <= CFG_WIDTH);
    assign accept    = push && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= 4'd2; step_reg <= 4'd2;
            height_reg <= 11'd32; width_reg <= 11'd32;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POOL:   pool_reg   <= cfg_data[3:0];
                CFG_STEP:   step_reg   <= cfg_data[3:0];
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // clamped view
    always_comb
    begin
        if (pool_reg == 4'd0) cfg.pool = 5'd1;
        else if (5'(pool_reg) > 5'(MAX_POOL)) cfg.pool = 5'(MAX_POOL);
        else cfg.pool = 5'(pool_reg);
        cfg.step = (step_reg == 4'd0) ? 4'd1 : step_reg;
        if (height_reg == 11'd0) cfg.height = 11'd1;
        else if (height_reg > 11'(ROW_LIMIT)) cfg.height = 11'(ROW_LIMIT);
        else cfg.height = height_reg;
        if (width_reg == 11'd0) cfg.width = (COL_W+1)'(1);
        else if ((COL_W+1)'(width_reg) > (COL_W+1)'(MAX_WIDTH)) cfg.width = (COL_W+1)'(MAX_WIDTH);
        else cfg.width = (COL_W+1)'(width_reg);
    end

    mpa_front #(.MAX_POOL(MAX_POOL)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .restart(cfg_hit),
        .accept(accept), .pix(pixel_bits), .item(front_item)
    );

    mpa_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr(accept), .wdata(front_item), .full(full),
        .rd(q_pop), .rdata(head), .empty(q_empty)
    );

    mpa_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_POOL(MAX_POOL)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .head(head), .q_empty(q_empty),
        .q_pop(q_pop), .empty(empty), .pop(pop), .max_bits(max_bits),
        .out_row(out_row), .out_col(out_col), .arg_row(arg_row), .arg_col(arg_col),
        .last_of_plane(last_of_plane)
    );
endmodule
`default_nettype wire
